// File: src/pcs_pkg.sv
// Shared constants and types for the periodic cell stencil block.
`timescale 1ns / 1ps
package pcs_pkg;

    localparam int CFG_W             = 9;
    localparam int CFG_ADDR_W        = 2;
    localparam int IDX_W             = 24;
    localparam int POS_W             = 5;
    localparam int DEFAULT_MAX_WIDTH = 256;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_Z = 2'd2;

    localparam logic [POS_W-1:0] FIRST_POS  = 5'd0;
    localparam logic [POS_W-1:0] CENTER_POS = 5'd13;
    localparam logic [POS_W-1:0] LAST_POS   = 5'd26;

    // stencil offset codes
    localparam logic [1:0] STEP_MINUS = 2'd0;
    localparam logic [1:0] STEP_ZERO  = 2'd1;
    localparam logic [1:0] STEP_PLUS  = 2'd2;

    typedef struct packed {
        logic err;
        logic single;
    } pcs_flags_t;

endpackage

// File: src/pcs_front.sv
// Front end: accepts cell indexes and splits them into x, y, z by radix-4 division.
`timescale 1ns / 1ps
module pcs_front #(
    parameter int MAX_WIDTH = pcs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [pcs_pkg::IDX_W-1:0]                  s_tdata,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]             wx,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]             wy,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]             wz,
    output logic                                       push,
    input  logic                                       full,
    output logic [3*$clog2(MAX_WIDTH+1)+1:0]           push_data
);
    import pcs_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int STEPS  = IDX_W / 2;
    localparam int CNT_W  = $clog2(STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV1 = 2'd1;
    localparam logic [1:0] ST_DIV2 = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] sh_reg, sh_next;
    logic [WW-1:0]    rem_reg, rem_next;
    logic [WW-1:0]    x_reg, x_next;
    logic [WW-1:0]    y_reg, y_next;

    logic [WW-1:0]    divisor;
    logic [WW:0]      t1, t2, r1, r2;
    logic             ge1, ge2;
    logic [IDX_W-1:0] sh_step;
    logic             last_step;
    pcs_flags_t       flags;

    // two restoring steps per cycle
    always_comb
    begin
        divisor = (state_reg == ST_DIV1) ? wx : wy;
        t1      = {rem_reg, sh_reg[IDX_W-1]};
        ge1     = (t1 >= {1'b0, divisor});
        r1      = ge1 ? (t1 - {1'b0, divisor}) : t1;
        t2      = {r1[WW-1:0], sh_reg[IDX_W-2]};
        ge2     = (t2 >= {1'b0, divisor});
        r2      = ge2 ? (t2 - {1'b0, divisor}) : t2;
        sh_step = {sh_reg[IDX_W-3:0], ge1, ge2};
    end

    assign last_step    = (cnt_reg == CNT_W'(STEPS - 1));
    assign s_tready     = (state_reg == ST_IDLE);
    assign flags.err    = (sh_reg >= IDX_W'(wz));
    assign flags.single = (wx == WW'(1));
    assign push         = (state_reg == ST_DONE) && !full;
    assign push_data    = {flags, sh_reg[WW-1:0], y_reg, x_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sh_next    = s_tdata;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                sh_next  = sh_step;
                rem_next = r2[WW-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    x_next     = r2[WW-1:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                sh_next  = sh_step;
                rem_next = r2[WW-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    y_next     = r2[WW-1:0];
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

endmodule

// File: src/pcs_fifo.sv
// Small register queue between the front end and the stencil generator.
`timescale 1ns / 1ps
module pcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/pcs_back.sv
// Back end: walks the 27 stencil offsets and forms each wrapped neighbor index.
`timescale 1ns / 1ps
module pcs_back #(
    parameter int MAX_WIDTH = pcs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       wx,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       wy,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       wz,
    input  logic [3*$clog2(MAX_WIDTH+1)+1:0]     head,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);
    import pcs_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PLW = 2 * WW;
    localparam int PW  = 3 * WW;
    localparam int CW  = (PW + 1 > IDX_W) ? PW + 1 : IDX_W;

    function automatic logic [WW-1:0] wrap(input logic [WW-1:0] c,
                                           input logic [1:0] d,
                                           input logic [WW-1:0] w);
        logic [WW-1:0] r;
        begin
            case (d)
                STEP_MINUS: r = (c == '0) ? w - WW'(1) : c - WW'(1);
                STEP_ZERO:  r = c;
                default:    r = (c == w - WW'(1)) ? '0 : c + WW'(1);
            endcase
            return r;
        end
    endfunction

    pcs_flags_t    h_flags;
    logic [WW-1:0] h_x, h_y, h_z;
    logic          en, issue, special, at_last;

    logic [PLW-1:0]   plane_reg;
    logic [1:0]       dx_reg, dy_reg, dz_reg;
    logic [POS_W-1:0] pos_reg;

    logic             a_v_reg;
    logic [WW-1:0]    a_x_reg, a_y_reg, a_z_reg;
    logic [POS_W-1:0] a_pos_reg;
    logic             a_last_reg, a_err_reg;

    logic             b_v_reg;
    logic [PW-1:0]    b_zp_reg;
    logic [PLW-1:0]   b_yp_reg;
    logic [WW-1:0]    b_x_reg;
    logic [POS_W-1:0] b_pos_reg;
    logic             b_last_reg, b_err_reg;

    logic             o_v_reg;
    logic [IDX_W-1:0] o_cell_reg;
    logic [POS_W-1:0] o_pos_reg;
    logic             o_last_reg, o_err_reg;
    logic [CW-1:0]    cell_sum;

    assign {h_flags, h_z, h_y, h_x} = head;

    assign en      = !o_v_reg || m_tready;
    assign issue   = en && !empty;
    assign special = h_flags.err || h_flags.single;
    assign at_last = (pos_reg == LAST_POS);
    assign pop     = issue && (special || at_last);

    assign cell_sum = CW'(b_zp_reg) + CW'(b_yp_reg) + CW'(b_x_reg);

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {{(32 - IDX_W - POS_W){1'b0}}, o_pos_reg, o_cell_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_err_reg;

    always_ff @(posedge clk)
    begin
        plane_reg <= PLW'(wx) * PLW'(wy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg  <= STEP_MINUS;
            dy_reg  <= STEP_MINUS;
            dz_reg  <= STEP_MINUS;
            pos_reg <= FIRST_POS;
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                dx_reg  <= STEP_MINUS;
                dy_reg  <= STEP_MINUS;
                dz_reg  <= STEP_MINUS;
                pos_reg <= FIRST_POS;
            end
            else if (issue)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (dx_reg == STEP_PLUS)
                begin
                    dx_reg <= STEP_MINUS;
                    if (dy_reg == STEP_PLUS)
                    begin
                        dy_reg <= STEP_MINUS;
                        dz_reg <= dz_reg + 2'd1;
                    end
                    else
                    begin
                        dy_reg <= dy_reg + 2'd1;
                    end
                end
                else
                begin
                    dx_reg <= dx_reg + 2'd1;
                end
            end
            if (en)
            begin
                a_v_reg <= issue;
                b_v_reg <= a_v_reg;
                o_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (special)
            begin
                a_x_reg    <= '0;
                a_y_reg    <= '0;
                a_z_reg    <= '0;
                a_pos_reg  <= h_flags.err ? FIRST_POS : CENTER_POS;
                a_last_reg <= 1'b1;
                a_err_reg  <= h_flags.err;
            end
            else
            begin
                a_x_reg    <= wrap(h_x, dx_reg, wx);
                a_y_reg    <= wrap(h_y, dy_reg, wy);
                a_z_reg    <= wrap(h_z, dz_reg, wz);
                a_pos_reg  <= pos_reg;
                a_last_reg <= at_last;
                a_err_reg  <= 1'b0;
            end

            b_zp_reg   <= PW'(a_z_reg) * PW'(plane_reg);
            b_yp_reg   <= PLW'(a_y_reg) * PLW'(wx);
            b_x_reg    <= a_x_reg;
            b_pos_reg  <= a_pos_reg;
            b_last_reg <= a_last_reg;
            b_err_reg  <= a_err_reg;

            o_cell_reg <= cell_sum[IDX_W-1:0];
            o_pos_reg  <= b_pos_reg;
            o_last_reg <= b_last_reg;
            o_err_reg  <= b_err_reg;
        end
    end

endmodule

// File: src/periodic_cell_stencil.sv
// Top level of the periodic 27-cell stencil generator.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata[23:0] cell_index
//  m_*     | out | m_tvalid/m_tready  | tdata[23:0] neighbor_cell, [28:24] position,
//          |     |                    | tlast last, tuser index_error
//  cfg_*   | in  | cfg_we             | cfg_addr register index, cfg_data value
//
// The front end takes a new request only once the last is handed off: an accept state, two
// radix-4 divisions (by width_x, then width_y), then a hand-off to the queue when not full.
// The back end issues one result per unstalled cycle: 27 per valid request, one otherwise,
// through a three-stage pipeline (wrap, multiply, add) into the output register.
// A full output register stalls the whole back end; a full queue stalls the front.
// Reset clears control state and sets all widths to 1; no clearing pass is needed.
`timescale 1ns / 1ps
module periodic_cell_stencil #(
    parameter int MAX_WIDTH = pcs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcs_pkg::IDX_W-1:0]       s_tdata,   // cell_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // neighbor_cell, stencil_position
    output logic                            m_tlast,
    output logic                            m_tuser,   // index_error
    input  logic                            cfg_we,
    input  logic [pcs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pcs_pkg::CFG_W-1:0]       cfg_data
);
    import pcs_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int QW = 3 * WW + 2;

    function automatic logic [WW-1:0] clamp(input logic [CFG_W-1:0] v);
        logic [WW-1:0] r;
        begin
            if (v == '0)
            begin
                r = WW'(1);
            end
            else if (int'(v) > MAX_WIDTH)
            begin
                r = WW'(MAX_WIDTH);
            end
            else
            begin
                r = WW'(v);
            end
            return r;
        end
    endfunction

    logic [WW-1:0] wx_reg, wy_reg, wz_reg;
    logic          push, full, pop, empty;
    logic [QW-1:0] push_data, head;

    // widths are stored already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg <= WW'(1);
            wy_reg <= WW'(1);
            wz_reg <= WW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH_X: wx_reg <= clamp(cfg_data);
                REG_WIDTH_Y: wy_reg <= clamp(cfg_data);
                REG_WIDTH_Z: wz_reg <= clamp(cfg_data);
                default:     ;
            endcase
        end
    end

    pcs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .wx        (wx_reg),
        .wy        (wy_reg),
        .wz        (wz_reg),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    pcs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    pcs_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wx       (wx_reg),
        .wy       (wy_reg),
        .wz       (wz_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the periodic 27-cell stencil generator.
`timescale 1ns / 1ps
module testbench;
    import pcs_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAUSE = 40;
    localparam int CELL_LIMIT  = 1 << IDX_W;

    typedef struct {
        logic [IDX_W-1:0] nbr_idx;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             err;
    } neighbor_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IDX_W-1:0]      s_tdata  = '0;   // cell_index
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;         // neighbor_cell, stencil_position
    logic                  m_tlast;
    logic                  m_tuser;         // index_error
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    logic [CFG_W-1:0] grid_x = 9'd1;
    logic [CFG_W-1:0] grid_y = 9'd1;
    logic [CFG_W-1:0] grid_z = 9'd1;

    neighbor_t   pending_neighbors[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int          hold_req       = 0;
    int          hold_ack       = 0;
    int          hold_left      = 0;

    periodic_cell_stencil u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("periodic_cell_stencil regression: fail");
        $finish;
    end

    function automatic int unsigned clamp_width(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > DEFAULT_MAX_WIDTH)
            return DEFAULT_MAX_WIDTH;
        return 32'(w);
    endfunction

    function automatic void add_pending(input neighbor_t r);
        pending_neighbors.insert(pending_neighbors.size(), r);
    endfunction

    function automatic void predict_stencil(input logic [IDX_W-1:0] idx);
        int unsigned wx, wy, wz, plane, cx, cy, cz, nx, ny, nz;
        neighbor_t   r;
        logic [POS_W-1:0] pos;
        wx    = clamp_width(grid_x);
        wy    = clamp_width(grid_y);
        wz    = clamp_width(grid_z);
        plane = wx * wy;
        r.err = 1'b0;
        if (idx >= plane * wz)
        begin
            r = '{nbr_idx: '0, pos: FIRST_POS, last: 1'b1, err: 1'b1};
            add_pending(r);
        end
        else if (wx == 1)
        begin
            r = '{nbr_idx: '0, pos: CENTER_POS, last: 1'b1, err: 1'b0};
            add_pending(r);
        end
        else
        begin
            cx  = idx % wx;
            cy  = (idx / wx) % wy;
            cz  = idx / plane;
            pos = FIRST_POS;
            for (int dz = 0; dz < 3; dz++)
                for (int dy = 0; dy < 3; dy++)
                    for (int dx = 0; dx < 3; dx++)
                    begin
                        nz        = (cz + wz + dz - 1) % wz;
                        ny        = (cy + wy + dy - 1) % wy;
                        nx        = (cx + wx + dx - 1) % wx;
                        r.nbr_idx = IDX_W'(nz * plane + ny * wx + nx);
                        r.pos     = pos;
                        r.last    = (pos == LAST_POS);
                        add_pending(r);
                        pos++;
                    end
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    // receiver: random backpressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        neighbor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_neighbors.size() == 0)
            begin
                report_mismatch("result with nothing pending, index",
                                32'(m_tdata[IDX_W-1:0]), 0);
            end
            else
            begin
                want = pending_neighbors.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.nbr_idx)
                    report_mismatch("neighbor_cell", 32'(m_tdata[IDX_W-1:0]),
                                    32'(want.nbr_idx));
                if (m_tdata[IDX_W+POS_W-1:IDX_W] !== want.pos)
                    report_mismatch("stencil_position", 32'(m_tdata[IDX_W+POS_W-1:IDX_W]),
                                    32'(want.pos));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                if (m_tuser !== want.err)
                    report_mismatch("index_error", 32'(m_tuser), 32'(want.err));
            end
        end
    end

    task automatic send_cell(input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        do
            @(posedge clk);
        while (!s_tready);
        predict_stencil(idx);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        case (addr)
            REG_WIDTH_X: grid_x = value;
            REG_WIDTH_Y: grid_y = value;
            REG_WIDTH_Z: grid_z = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] wx, wy, wz);
        wait_for_results();
        write_width(REG_WIDTH_X, wx);
        write_width(REG_WIDTH_Y, wy);
        write_width(REG_WIDTH_Z, wz);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return CFG_W'($urandom_range(6, 2));
        if (roll < 55) return 9'd1;
        if (roll < 65) return 9'd3;
        if (roll < 75) return 9'd0;
        if (roll < 85) return CFG_W'($urandom_range(511, 257));
        return CFG_W'($urandom_range(DEFAULT_MAX_WIDTH, 7));
    endfunction

    task automatic test_power_on_grid();
        send_cell(24'd0);
        send_cell(24'd1);
        send_cell(24'hFFFFFF);
    endtask

    task automatic test_cube_corners();
        set_grid(9'd3, 9'd3, 9'd3);
        send_cell(24'd0);
        send_cell(24'd13);
        send_cell(24'd26);
        send_cell(24'd27);
        set_grid(9'd2, 9'd2, 9'd2);
        send_cell(24'd0);
        send_cell(24'd7);
    endtask

    task automatic test_width_clamping();
        set_grid(9'd256, 9'd256, 9'd256);
        send_cell(24'd0);
        send_cell(24'h800000);
        send_cell(24'hFFFFFF);
        set_grid(9'd511, 9'd0, 9'd300);
        send_cell(24'd0);
        send_cell(24'd65535);
        send_cell(24'd65536);
        send_cell(24'hFFFFFF);
        set_grid(9'd256, 9'd1, 9'd0);
        send_cell(24'd255);
    endtask

    task automatic test_single_column();
        set_grid(9'd0, 9'd5, 9'd5);
        send_cell(24'd24);
        send_cell(24'd25);
        set_grid(9'd2, 9'd1, 9'd1);
        send_cell(24'd1);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3)
        begin
            set_grid(pick_width(), pick_width(), pick_width());
            count = clamp_width(grid_x) * clamp_width(grid_y) * clamp_width(grid_z);
            repeat (30)
            begin
                if ($urandom_range(99) < 15 && count < CELL_LIMIT)
                    send_cell(IDX_W'($urandom_range(CELL_LIMIT - 1, count)));
                else if ($urandom_range(99) < 5)
                    send_cell(IDX_W'($urandom()));
                else
                    send_cell(IDX_W'($urandom_range(count - 1, 0)));
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grid(9'd4, 9'd4, 9'd4);
        hold_req <= hold_req + 1;
        repeat (8) send_cell(IDX_W'($urandom_range(63, 0)));
        wait_for_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 69;
        test_power_on_grid();
        test_cube_corners();
        test_width_clamping();
        test_single_column();
        test_random_traffic(10, 69);
        test_random_traffic(69, 10);
        test_random_traffic(0, 0);
        test_output_backpressure();
        wait_for_results();
        if (mismatch_count == 0)
            $display("periodic_cell_stencil regression: pass");
        else
            $display("periodic_cell_stencil regression: fail");
        $finish;
    end

endmodule
